// ----- rtl/mutual_best_match_decoder_assert.svh -----
// Assertion macros shared by the decoder; define NO_ASSERTIONS to drop them.
`ifndef MUTUAL_BEST_MATCH_DECODER_ASSERT_SVH
`define MUTUAL_BEST_MATCH_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define MBM_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mutual_best_match_decoder: assertion failed");
// Next-cycle implication.
`define MBM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mutual_best_match_decoder: assertion failed");
`else
`define MBM_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define MBM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- rtl/mbm_pkg.sv -----
package mbm_pkg;

    localparam int MAX_POINTS  = 2048;
    localparam int PT_BITS     = $clog2(MAX_POINTS);
    localparam int SIZE_BITS   = 12;
    localparam int SCORE_BITS  = 16;
    localparam int PROB_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // Opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_QROW = 2'd1;
    localparam logic [1:0] OP_QCOL = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR  = 2'd2;

    localparam logic [SIZE_BITS-1:0] SIZE_MIN = 12'd2;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = 12'd2049;
    localparam logic [PROB_BITS-1:0] THR_RESET = 16'd13107;

    // Exp series
    localparam int TERMS     = 20;
    localparam int TERM_BITS = 33;
    localparam int SUM_BITS  = 35;
    localparam int ACC_BITS  = 34;
    localparam int FRAC_BITS = 10;
    localparam int WHOLE_BITS = 4;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] value;
        logic [PT_BITS-1:0]           index;
    } t_best;

    localparam int BEST_BITS = $bits(t_best);

    typedef enum logic [2:0] {
        CS_IDLE, CS_LD_RD, CS_LD_WR, CS_Q_RD1, CS_Q_RD2, CS_Q_CHK, CS_Q_SEL, CS_Q_EXP
    } t_ctrl_state;

    typedef enum logic [2:0] {
        EX_IDLE, EX_MUL, EX_DIV, EX_ACC, EX_END, EX_POW, EX_DONE
    } t_exp_state;

    typedef struct packed {
        logic capture;
        logic ld_read;
        logic ld_write;
        logic q_read1;
        logic q_read2;
        logic q_check;
        logic exp_start;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_exp;
        logic exp_done;
        logic out_busy;
    } t_dp_status;

    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] r;
        r = v;
        if (v < SIZE_MIN) r = SIZE_MIN;
        if (v > SIZE_MAX) r = SIZE_MAX;
        return r;
    endfunction

endpackage

// ----- rtl/mutual_best_match_decoder.sv -----
// Mutual best-match decoder. Load beats (opcode 0) stream a row-major log-score
// matrix, signed Q5.10, whose last row and column are dustbins; row and column
// maxima with their indexes go to two 2048-entry RAMs. Query beats (opcode 1 for
// a row, 2 for a column) return the partner index, the exp score in Q0.16 and
// the mutual flag; opcode 3 is dropped. One item is in work at a time: a load
// goes through accept, column RAM read, and compare and write back. A query
// goes through accept, two dependent RAM reads, mutual check and result load,
// and waits longer while the previous result is still held in the output
// register. When the match is mutual and its log score lies in (-16, 0) the
// query also waits for the exp unit, which runs two 19-term series, each term
// one multiply, a bit-serial division and an accumulate, then one multiply per
// whole unit of the score. Write rows_in_use, cols_in_use and match_threshold
// through the configuration port while the block is idle; a size write
// restarts loading at row 0, column 0.
module mutual_best_match_decoder
    import mbm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic signed [SCORE_BITS-1:0] i_log_score,
    input  logic [PT_BITS-1:0]           i_point_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SIZE_BITS-1:0]  o_matched_index,
    output logic [PROB_BITS-1:0]         o_match_score,
    output logic                         o_is_mutual,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data
);

    `include "mutual_best_match_decoder_assert.svh"

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    mbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mbm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_opcode        (i_opcode),
        .i_log_score     (i_log_score),
        .i_point_index   (i_point_index),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_matched_index (o_matched_index),
        .o_match_score   (o_match_score),
        .o_is_mutual     (o_is_mutual)
    );

    // A load keeps the engine busy in the next cycle
    `MBM_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_opcode == OP_LOAD, !o_in_ready)
    // A non-mutual result carries no score and no partner
    `MBM_ASSERT_IMPLY(a_no_mutual, i_clk, i_rst_n, o_out_valid && !o_is_mutual, o_match_score == '0 && o_matched_index == '1)
    // A partner is only given for a mutual match
    `MBM_ASSERT_IMPLY(a_partner_mutual, i_clk, i_rst_n, o_out_valid && o_matched_index != '1, o_is_mutual)

endmodule

// ----- rtl/mbm_ram.sv -----
module mbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mbm_exp.sv -----
module mbm_exp
    import mbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [FRAC_BITS-1:0]  i_frac,
    input  logic [WHOLE_BITS-1:0] i_whole,
    output logic                  o_done,
    output logic [PROB_BITS-1:0]  o_score
);

    localparam int MUL_BITS = TERM_BITS + FRAC_BITS + 1;
    localparam int QUO_BITS = MUL_BITS - FRAC_BITS;
    localparam int M_BITS   = $clog2(TERMS);
    localparam int BIT_BITS = $clog2(QUO_BITS);
    localparam int POW_BITS = 2 * ACC_BITS;

    t_exp_state r_state, n_state;

    logic                  r_phase;
    logic [FRAC_BITS:0]    r_v;
    logic [FRAC_BITS-1:0]  r_frac;
    logic [WHOLE_BITS-1:0] r_k;
    logic [TERM_BITS-1:0]  r_term;
    logic [SUM_BITS-1:0]   r_even, r_odd;
    logic [M_BITS-1:0]     r_m;
    logic [QUO_BITS-1:0]   r_quo;
    logic [M_BITS-1:0]     r_rem;
    logic [BIT_BITS-1:0]   r_bit;
    logic [ACC_BITS-1:0]   r_e1, r_acc;

    logic [MUL_BITS-1:0]   w_prod;
    logic [M_BITS:0]       w_rem_sh;
    logic                  w_ge;
    logic [M_BITS:0]       w_rem_sub;
    logic [ACC_BITS-1:0]   w_series;
    logic [POW_BITS-1:0]   w_pow;
    logic [ACC_BITS:0]     w_round;

    assign w_prod    = MUL_BITS'(r_term) * MUL_BITS'(r_v);
    assign w_rem_sh  = {r_rem, r_quo[QUO_BITS-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_m};
    assign w_rem_sub = w_rem_sh - {1'b0, r_m};
    assign w_series  = (r_even > r_odd) ? ACC_BITS'(r_even - r_odd) : '0;
    assign w_pow     = POW_BITS'(r_acc) * POW_BITS'(r_e1) + (POW_BITS'(1) << 31);
    assign w_round   = {1'b0, r_acc} + (ACC_BITS+1)'(32768);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EX_IDLE: if (i_start) n_state = EX_MUL;
            EX_MUL:  n_state = EX_DIV;
            EX_DIV:  if (r_bit == BIT_BITS'(QUO_BITS - 1)) n_state = EX_ACC;
            EX_ACC:  n_state = (r_m == M_BITS'(TERMS - 1)) ? EX_END : EX_MUL;
            EX_END: begin
                if (!r_phase) n_state = EX_MUL;
                else n_state = (r_k == '0) ? EX_DONE : EX_POW;
            end
            EX_POW:  if (r_k == WHOLE_BITS'(1)) n_state = EX_DONE;
            EX_DONE: n_state = EX_IDLE;
            default: n_state = EX_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EX_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Series and power registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            EX_IDLE: begin
                if (i_start) begin
                    r_frac  <= i_frac;
                    r_k     <= i_whole;
                    r_phase <= 1'b0;
                    r_v     <= (FRAC_BITS+1)'(1 << FRAC_BITS);
                    r_term  <= TERM_BITS'(1) << 32;
                    r_even  <= SUM_BITS'(1) << 32;
                    r_odd   <= '0;
                    r_m     <= M_BITS'(1);
                end
            end
            EX_MUL: begin
                r_quo <= w_prod[MUL_BITS-1:FRAC_BITS];
                r_rem <= '0;
                r_bit <= '0;
            end
            EX_DIV: begin
                r_rem <= w_ge ? w_rem_sub[M_BITS-1:0] : w_rem_sh[M_BITS-1:0];
                r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
                r_bit <= r_bit + BIT_BITS'(1);
            end
            EX_ACC: begin
                r_term <= r_quo[TERM_BITS-1:0];
                if (r_m[0]) r_odd <= r_odd + SUM_BITS'(r_quo[TERM_BITS-1:0]);
                else r_even <= r_even + SUM_BITS'(r_quo[TERM_BITS-1:0]);
                r_m <= r_m + M_BITS'(1);
            end
            EX_END: begin
                if (!r_phase) begin
                    r_e1    <= w_series;
                    r_phase <= 1'b1;
                    r_v     <= {1'b0, r_frac};
                    r_term  <= TERM_BITS'(1) << 32;
                    r_even  <= SUM_BITS'(1) << 32;
                    r_odd   <= '0;
                    r_m     <= M_BITS'(1);
                end else begin
                    r_acc <= w_series;
                end
            end
            EX_POW: begin
                r_acc <= w_pow[ACC_BITS+31:32];
                r_k   <= r_k - WHOLE_BITS'(1);
            end
            default: ;
        endcase
    end

    assign o_done  = (r_state == EX_DONE);
    assign o_score = (w_round[ACC_BITS:16] > (ACC_BITS-15)'(65535)) ? '1 : w_round[31:16];

endmodule

// ----- rtl/mbm_ctrl.sv -----
module mbm_ctrl
    import mbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_LOAD) n_state = CS_LD_RD;
                    else if (i_opcode == OP_QROW || i_opcode == OP_QCOL) n_state = CS_Q_RD1;
                end
            end
            CS_LD_RD: n_state = CS_LD_WR;
            CS_LD_WR: n_state = CS_IDLE;
            CS_Q_RD1: n_state = CS_Q_RD2;
            CS_Q_RD2: n_state = CS_Q_CHK;
            CS_Q_CHK: n_state = CS_Q_SEL;
            CS_Q_SEL: begin
                if (i_status.need_exp) n_state = CS_Q_EXP;
                else if (!i_status.out_busy) n_state = CS_IDLE;
            end
            CS_Q_EXP: if (i_status.exp_done) n_state = CS_Q_SEL;
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            CS_LD_RD: o_cmd.ld_read  = 1'b1;
            CS_LD_WR: o_cmd.ld_write = 1'b1;
            CS_Q_RD1: o_cmd.q_read1  = 1'b1;
            CS_Q_RD2: o_cmd.q_read2  = 1'b1;
            CS_Q_CHK: o_cmd.q_check  = 1'b1;
            CS_Q_SEL: begin
                o_cmd.exp_start = i_status.need_exp;
                o_cmd.out_load  = !i_status.need_exp && !i_status.out_busy;
            end
            CS_Q_EXP: ;
            default: ;
        endcase
    end

endmodule

// ----- rtl/mbm_dp.sv -----
module mbm_dp
    import mbm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic [1:0]               i_opcode,
    input  logic signed [SCORE_BITS-1:0] i_log_score,
    input  logic [PT_BITS-1:0]       i_point_index,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [SIZE_BITS-1:0] o_matched_index,
    output logic [PROB_BITS-1:0]     o_match_score,
    output logic                     o_is_mutual
);

    logic [SIZE_BITS-1:0] r_rows, r_cols, r_load_row, r_load_col;
    logic [PROB_BITS-1:0] r_thr;
    logic signed [SCORE_BITS-1:0] r_run_max, r_score_in, r_val;
    logic [PT_BITS-1:0] r_run_arg, r_point, r_partner;
    logic [1:0] r_op;
    logic r_real, r_mutual, r_need_exp, r_exp_pending;
    logic r_out_valid, r_out_mutual;
    logic [SIZE_BITS-1:0] r_out_index;
    logic [PROB_BITS-1:0] r_out_score;

    t_best w_row_rd, w_col_rd, w_row_wd, w_col_wd;
    logic w_row_we, w_col_we, w_row_re, w_col_re;
    logic [PT_BITS-1:0] w_row_ra, w_col_ra;

    logic [SIZE_BITS-1:0] w_rr, w_cc, w_c_inc, w_r_inc;
    logic w_in_range, w_last_col, w_run_take, w_col_take;
    logic signed [SCORE_BITS-1:0] w_new_max;
    logic [PT_BITS-1:0] w_new_arg;
    logic [SCORE_BITS:0] w_mag;
    logic w_k_big, w_exp_done;
    logic [PROB_BITS-1:0] w_exp_score, w_score;
    logic w_val_need_exp;

    // Load path
    assign w_rr       = clamp_size(r_rows);
    assign w_cc       = clamp_size(r_cols);
    assign w_in_range = (r_load_row < w_rr - SIZE_BITS'(1)) && (r_load_col < w_cc - SIZE_BITS'(1));
    assign w_last_col = (r_load_col == w_cc - SIZE_BITS'(2));
    assign w_run_take = (r_load_col == '0) || (r_score_in > r_run_max);
    assign w_new_max  = w_run_take ? r_score_in : r_run_max;
    assign w_new_arg  = w_run_take ? r_load_col[PT_BITS-1:0] : r_run_arg;
    assign w_col_take = (r_load_row == '0) || (r_score_in > w_col_rd.value);
    assign w_c_inc    = r_load_col + SIZE_BITS'(1);
    assign w_r_inc    = r_load_row + SIZE_BITS'(1);

    // RAM ports
    always_comb begin
        w_row_we       = i_cmd.ld_write && w_in_range && w_last_col;
        w_row_wd.value = w_new_max;
        w_row_wd.index = w_new_arg;
        w_col_we       = i_cmd.ld_write && w_in_range && w_col_take;
        w_col_wd.value = r_score_in;
        w_col_wd.index = r_load_row[PT_BITS-1:0];
        w_row_re = (i_cmd.q_read1 && r_op == OP_QROW) || (i_cmd.q_read2 && r_op == OP_QCOL);
        w_row_ra = i_cmd.q_read1 ? r_point : w_col_rd.index;
        w_col_re = i_cmd.ld_read || (i_cmd.q_read1 && r_op == OP_QCOL)
                || (i_cmd.q_read2 && r_op == OP_QROW);
        w_col_ra = i_cmd.ld_read ? r_load_col[PT_BITS-1:0]
                 : (i_cmd.q_read1 ? r_point : w_row_rd.index);
    end

    mbm_ram #(.WIDTH(BEST_BITS), .DEPTH(MAX_POINTS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (r_load_row[PT_BITS-1:0]),
        .i_wdata (w_row_wd),
        .i_re    (w_row_re),
        .i_raddr (w_row_ra),
        .o_rdata (w_row_rd)
    );

    mbm_ram #(.WIDTH(BEST_BITS), .DEPTH(MAX_POINTS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (r_load_col[PT_BITS-1:0]),
        .i_wdata (w_col_wd),
        .i_re    (w_col_re),
        .i_raddr (w_col_ra),
        .o_rdata (w_col_rd)
    );

    // Score of the row maximum
    assign w_mag   = (SCORE_BITS+1)'(-$signed({r_val[SCORE_BITS-1], r_val}));
    assign w_k_big = (w_mag[SCORE_BITS:FRAC_BITS+WHOLE_BITS] != '0);
    assign w_val_need_exp = r_mutual && r_val[SCORE_BITS-1] && !w_k_big;

    mbm_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exp_start),
        .i_frac  (w_mag[FRAC_BITS-1:0]),
        .i_whole (w_mag[FRAC_BITS+WHOLE_BITS-1:FRAC_BITS]),
        .o_done  (w_exp_done),
        .o_score (w_exp_score)
    );

    always_comb begin
        if (!r_mutual) w_score = '0;
        else if (!r_val[SCORE_BITS-1]) w_score = '1;
        else if (w_k_big) w_score = '0;
        else w_score = w_exp_score;
    end

    // Configuration and load counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= SIZE_MAX;
            r_cols     <= SIZE_MAX;
            r_thr      <= THR_RESET;
            r_load_row <= '0;
            r_load_col <= '0;
            r_run_max  <= {1'b1, {(SCORE_BITS-1){1'b0}}};
            r_run_arg  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS: begin
                    r_rows     <= i_cfg_data[SIZE_BITS-1:0];
                    r_load_row <= '0;
                    r_load_col <= '0;
                end
                CFG_COLS: begin
                    r_cols     <= i_cfg_data[SIZE_BITS-1:0];
                    r_load_row <= '0;
                    r_load_col <= '0;
                end
                CFG_THR: r_thr <= i_cfg_data[PROB_BITS-1:0];
                default: ;
            endcase
        end else if (i_cmd.ld_write) begin
            if (w_in_range) begin
                r_run_max <= w_new_max;
                r_run_arg <= w_new_arg;
            end
            if (w_c_inc >= w_cc) begin
                r_load_col <= '0;
                r_load_row <= (w_r_inc >= w_rr) ? '0 : w_r_inc;
            end else begin
                r_load_col <= w_c_inc;
            end
        end
    end

    // Item capture and query registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_score_in <= i_log_score;
            r_point    <= i_point_index;
        end
        if (i_cmd.q_read2) begin
            r_partner <= (r_op == OP_QROW) ? w_row_rd.index : w_col_rd.index;
            r_real    <= (r_op == OP_QROW) ? ({1'b0, r_point} < w_rr - SIZE_BITS'(1))
                                           : ({1'b0, r_point} < w_cc - SIZE_BITS'(1));
            r_val     <= w_row_rd.value;
        end
        if (i_cmd.q_check) begin
            if (r_op == OP_QROW) begin
                r_mutual <= r_real && (w_col_rd.index == r_point);
            end else begin
                r_mutual <= r_real && (w_row_rd.index == r_point);
                r_val    <= w_row_rd.value;
            end
        end
    end

    // Exp request tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need_exp    <= 1'b0;
            r_exp_pending <= 1'b0;
        end else begin
            if (i_cmd.q_check) r_exp_pending <= 1'b1;
            else if (i_cmd.exp_start || i_cmd.out_load) r_exp_pending <= 1'b0;
            r_need_exp <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index  <= (r_mutual && (w_score > r_thr)) ? {1'b0, r_partner} : '1;
            r_out_score  <= w_score;
            r_out_mutual <= r_mutual;
        end
    end

    assign o_status.need_exp = r_exp_pending && w_val_need_exp && !r_need_exp;
    assign o_status.exp_done = w_exp_done;
    assign o_status.out_busy = r_out_valid;

    assign o_out_valid     = r_out_valid;
    assign o_matched_index = r_out_index;
    assign o_match_score   = r_out_score;
    assign o_is_mutual     = r_out_mutual;

endmodule
